[hdl/digit_trie_prefix_checker_macros.svh]
// assertion macros shared by the digit trie prefix checker modules
`ifndef DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH
`define DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH

// same-cycle implication
`define DTPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtpc assertion failed");

// next-cycle implication
`define DTPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtpc assertion failed");

`endif

[hdl/dtpc_pkg.sv]
// shared types and constants for the digit trie prefix checker
`timescale 1ns / 1ps

package dtpc_pkg;

   localparam int NODE_COUNT_DEF = 4096;
   localparam int MAX_DIGITS_DEF = 10;
   localparam int RADIX          = 10;
   localparam int DIGIT_W        = 4;
   localparam int DIGITS_W       = 40;
   localparam int LEN_W          = 4;
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 8;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      KIND_CHECK = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_STEP,
      W_PTR,
      W_FIN
   } walk_state_type;

   typedef struct packed {
      kind_type              kind;
      logic [DIGITS_W-1:0]   digits;
      logic [LEN_W-1:0]      len;
   } item_type;

   // bit order matches the result transaction, prefix_found in bit 0
   typedef struct packed {
      logic                  pool_full;
      logic                  list_consistent;
      logic [LEN_W-1:0]      prefix_length;
      logic                  prefix_found;
   } result_type;

endpackage

[hdl/dtpc_front.sv]
// input stage: takes request transactions, decodes kind and clamps length
`timescale 1ns / 1ps

module dtpc_front #(
   parameter int MAX_DIGITS = dtpc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dtpc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [0:0]                       req_tuser,
   output logic                             push_valid,
   input  logic                             push_ready,
   output dtpc_pkg::item_type               push_item
);

   logic                  hold_valid_ff, hold_valid_in;
   dtpc_pkg::item_type    hold_item_ff, hold_item_in;
   logic [dtpc_pkg::LEN_W-1:0] raw_len;
   logic                  accept;

   assign raw_len    = req_tdata[dtpc_pkg::DIGITS_W +: dtpc_pkg::LEN_W];
   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (hold_valid_ff && push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in       = 1'b1;
         hold_item_in.kind   = dtpc_pkg::kind_type'(req_tuser[0]);
         hold_item_in.digits = req_tdata[dtpc_pkg::DIGITS_W-1:0];
         // clamp length to the deepest walk
         if ({1'b0, raw_len} > (dtpc_pkg::LEN_W+1)'(MAX_DIGITS)) begin
            hold_item_in.len = dtpc_pkg::LEN_W'(MAX_DIGITS);
         end else begin
            hold_item_in.len = raw_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

[hdl/dtpc_queue.sv]
// small fifo between the input stage and the trie walker
`timescale 1ns / 1ps
`include "digit_trie_prefix_checker_macros.svh"

module dtpc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dtpc_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dtpc_pkg::item_type  pop_item
);

   localparam int DEPTH = dtpc_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   dtpc_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `DTPC_ASSERT_NOW(a_queue_count, clock, reset, 1'b1, count_ff <= CW'(DEPTH))

endmodule

[hdl/dtpc_walker.sv]
// trie walker: node memories, walk and insert sequencer, result register
`timescale 1ns / 1ps
`include "digit_trie_prefix_checker_macros.svh"

module dtpc_walker #(
   parameter int NODE_COUNT = dtpc_pkg::NODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  dtpc_pkg::item_type                pop_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dtpc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int NW        = $clog2(NODE_COUNT);
   localparam int NFW       = NW + 1;
   localparam int PTR_DEPTH = NODE_COUNT * dtpc_pkg::RADIX;
   localparam int AW        = $clog2(PTR_DEPTH);
   localparam int RX        = dtpc_pkg::RADIX;
   localparam int DW        = dtpc_pkg::DIGIT_W;
   localparam int LW        = dtpc_pkg::LEN_W;
   localparam int XW        = dtpc_pkg::DIGITS_W;

   // child pointer per node and digit, node word is {end_mark, child_valid}
   logic [NW-1:0] ptr_mem  [PTR_DEPTH];
   logic [RX:0]   node_mem [NODE_COUNT];

   logic          ptr_we;
   logic [AW-1:0] ptr_addr;
   logic [NW-1:0] ptr_wdata;
   logic [NW-1:0] ptr_q;
   logic          node_we;
   logic [NW-1:0] node_waddr;
   logic [RX:0]   node_wdata;
   logic [RX:0]   node_q;

   dtpc_pkg::walk_state_type state_ff, state_in;
   logic [NW-1:0]   cur_ff, cur_in;
   logic [RX-1:0]   cur_valid_ff, cur_valid_in;
   logic            cur_new_ff, cur_new_in;
   logic            from_mem_ff, from_mem_in;
   logic [XW-1:0]   dig_ff, dig_in;
   logic [LW-1:0]   rem_ff, rem_in;
   logic [LW-1:0]   idx_ff, idx_in;
   logic [RX-1:0]   root_valid_ff, root_valid_in;
   logic [NFW-1:0]  next_free_ff, next_free_in;
   logic            consistent_ff, consistent_in;
   dtpc_pkg::result_type res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   dtpc_pkg::result_type rsp_res_ff, rsp_res_in;

   logic [RX-1:0]   eff_valid;
   logic            eff_end;
   logic [DW-1:0]   digit;
   logic            digit_ok;
   logic [15:0]     valid_wide;
   logic            child_there;
   logic            pool_empty;
   logic [RX-1:0]   digit_bit;
   logic [AW-1:0]   cur_ext;
   logic            complete;
   logic            alloc;

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_addr] <= ptr_wdata;
      end
      ptr_q <= ptr_mem[ptr_addr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_q <= node_mem[ptr_q];
   end

   // node word of the current node comes from memory right after a pointer hop
   assign eff_valid   = from_mem_ff ? node_q[RX-1:0] : cur_valid_ff;
   assign eff_end     = from_mem_ff && node_q[RX];
   assign digit       = dig_ff[DW-1:0];
   assign digit_ok    = digit < DW'(RX);
   assign valid_wide  = {{(16-RX){1'b0}}, eff_valid};
   assign child_there = digit_ok && valid_wide[digit];
   assign pool_empty  = next_free_ff >= NFW'(NODE_COUNT);
   assign digit_bit   = RX'(1) << digit;
   assign cur_ext     = AW'(cur_ff);
   assign ptr_addr    = (cur_ext << 3) + (cur_ext << 1) + AW'(digit);
   assign ptr_wdata   = next_free_ff[NW-1:0];
   assign complete    = rem_ff == '0;

   assign pop_ready  = state_ff == dtpc_pkg::W_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dtpc_pkg::RSP_DATA_W - $bits(dtpc_pkg::result_type)){1'b0}},
                        rsp_res_ff};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      cur_new_in    = cur_new_ff;
      from_mem_in   = 1'b0;
      dig_in        = dig_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      root_valid_in = root_valid_ff;
      next_free_in  = next_free_ff;
      consistent_in = consistent_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_res_in    = rsp_res_ff;
      ptr_we        = 1'b0;
      node_we       = 1'b0;
      node_waddr    = cur_ff;
      node_wdata    = {1'b0, eff_valid};
      alloc         = 1'b0;

      case (state_ff)
         dtpc_pkg::W_IDLE: begin
            if (pop_valid) begin
               res_in   = '0;
               state_in = dtpc_pkg::W_FIN;
               case (pop_item.kind)
                  dtpc_pkg::KIND_CLEAR: begin
                     root_valid_in          = '0;
                     next_free_in           = NFW'(1);
                     consistent_in          = 1'b1;
                     res_in.list_consistent = 1'b1;
                  end
                  default: begin
                     if (consistent_ff) begin
                        cur_in       = '0;
                        cur_valid_in = root_valid_ff;
                        cur_new_in   = 1'b0;
                        dig_in       = pop_item.digits;
                        rem_in       = pop_item.len;
                        idx_in       = '0;
                        state_in     = dtpc_pkg::W_STEP;
                     end
                  end
               endcase
            end
         end

         dtpc_pkg::W_STEP: begin
            cur_valid_in = eff_valid;
            if (eff_end) begin
               // stored number is a prefix of this one
               consistent_in          = 1'b0;
               res_in.prefix_found    = 1'b1;
               res_in.prefix_length   = idx_ff;
               res_in.list_consistent = 1'b0;
               state_in               = dtpc_pkg::W_FIN;
            end else if (complete || !digit_ok || (!child_there && pool_empty)) begin
               // walk ends: mark the end, or flush a fresh node that stays empty
               node_we    = (cur_ff != '0) && (complete || cur_new_ff);
               node_wdata = {complete, eff_valid};
               res_in.list_consistent = consistent_ff;
               res_in.pool_full       = !complete && digit_ok;
               state_in   = dtpc_pkg::W_FIN;
            end else begin
               dig_in = dig_ff >> DW;
               rem_in = rem_ff - LW'(1);
               idx_in = idx_ff + LW'(1);
               if (child_there) begin
                  state_in = dtpc_pkg::W_PTR;
               end else begin
                  alloc  = 1'b1;
                  ptr_we = 1'b1;
                  if (cur_ff == '0) begin
                     root_valid_in = eff_valid | digit_bit;
                  end else begin
                     node_we    = 1'b1;
                     node_wdata = {1'b0, eff_valid | digit_bit};
                  end
                  cur_in       = next_free_ff[NW-1:0];
                  cur_valid_in = '0;
                  cur_new_in   = 1'b1;
                  next_free_in = next_free_ff + NFW'(1);
               end
            end
         end

         dtpc_pkg::W_PTR: begin
            cur_in      = ptr_q;
            cur_new_in  = 1'b0;
            from_mem_in = 1'b1;
            state_in    = dtpc_pkg::W_STEP;
         end

         dtpc_pkg::W_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = dtpc_pkg::W_IDLE;
            end
         end

         default: begin
            state_in = dtpc_pkg::W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtpc_pkg::W_IDLE;
         from_mem_ff   <= 1'b0;
         root_valid_ff <= '0;
         next_free_ff  <= NFW'(1);
         consistent_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         from_mem_ff   <= from_mem_in;
         root_valid_ff <= root_valid_in;
         next_free_ff  <= next_free_in;
         consistent_ff <= consistent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      cur_valid_ff <= cur_valid_in;
      cur_new_ff   <= cur_new_in;
      dig_ff       <= dig_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      res_ff       <= res_in;
      rsp_res_ff   <= rsp_res_in;
   end

   `DTPC_ASSERT_NOW(a_free_range, clock, reset, 1'b1, (next_free_ff >= NFW'(1)) && (next_free_ff <= NFW'(NODE_COUNT)))
   `DTPC_ASSERT_NEXT(a_alloc_bump, clock, reset, alloc, next_free_ff == $past(next_free_ff) + NFW'(1))
   `DTPC_ASSERT_NOW(a_hop_not_root, clock, reset, state_ff == dtpc_pkg::W_PTR, ptr_q != '0)
   `DTPC_ASSERT_NOW(a_found_sticky, clock, reset, (state_ff == dtpc_pkg::W_FIN) && res_ff.prefix_found, !consistent_ff)

endmodule

[hdl/digit_trie_prefix_checker.sv]
// top level of the digit trie prefix checker
`timescale 1ns / 1ps
// the walker takes one transaction at a time; per digit followed it reads the pointer memory,
// then the node memory, and a created node needs no memory read
// clear and ignored transactions go straight to the result state in the walker
// reset: synchronous, empties the trie at once (root only), no memory sweep

module digit_trie_prefix_checker #(
   parameter int NODE_COUNT = dtpc_pkg::NODE_COUNT_DEF,
   parameter int MAX_DIGITS = dtpc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // digits [39:0], length [43:40], zero padding [47:44]
   input  logic [dtpc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action [0]: check and insert, or clear
   input  logic [0:0]                       req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // prefix_found [0], prefix_length [4:1], list_consistent [5], pool_full [6], zero [7]
   output logic [dtpc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // front to queue
   logic               push_valid;
   logic               push_ready;
   dtpc_pkg::item_type push_item;

   // queue to walker
   logic               pop_valid;
   logic               pop_ready;
   dtpc_pkg::item_type pop_item;

   // accepts transactions, decodes the action and clamps the length
   dtpc_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // short fifo so the input side keeps taking transactions during a walk
   dtpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // walks and extends the trie, owns the result register
   dtpc_walker #(
      .NODE_COUNT (NODE_COUNT)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[dv/tb.sv]
// self-checking testbench for the digit trie prefix checker
`timescale 1ns / 1ps

module tb;

   localparam int NODES  = dtpc_pkg::NODE_COUNT_DEF;
   localparam int DEPTH  = dtpc_pkg::MAX_DIGITS_DEF;
   localparam int RADIX  = dtpc_pkg::RADIX;
   localparam int DIGITS_W = dtpc_pkg::DIGITS_W;
   localparam int LEN_W  = dtpc_pkg::LEN_W;
   localparam int REQ_DATA_W = dtpc_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = dtpc_pkg::RSP_DATA_W;
   localparam int HOLD_AT_RESULT = 40;   // result count that starts the long receiver hold
   localparam int HOLD_CYCLES    = 300;

   // a request waiting to be driven; drain makes the sender wait for all results first
   typedef struct {
      dtpc_pkg::item_type item;
      bit                 drain;
   } queued_item_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // digits [39:0], length [43:40], zero padding [47:44]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // action [0]
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // prefix_found [0], prefix_length [4:1], list_consistent [5], pool_full [6], zero [7]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   digit_trie_prefix_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow trie: child pointers, child-present bits, end marks, allocator, conflict flag
   logic [11:0]     node_child [NODES*RADIX];
   logic [RADIX-1:0] node_kids [NODES];
   bit              node_end   [NODES];
   int unsigned     alloc_next;
   bit              list_ok;

   queued_item_type        pending_items[$];
   dtpc_pkg::result_type   awaited_results[$];

   int unsigned     mismatches   = 0;
   int unsigned     results_seen = 0;
   bit              req_taken    = 1'b0;   // set at the rising edge, consumed by the driver
   bit              rsp_taken    = 1'b0;   // set at the rising edge, consumed by the receiver
   bit              send_burst   = 1'b0;
   bit              take_burst   = 1'b0;
   int unsigned     send_gap     = 0;
   int unsigned     stall_left   = 0;
   int unsigned     hold_left    = 0;

   // empty trie: root only, list consistent
   function automatic void trie_empty();
      node_kids[0] = '0;
      node_end[0]  = 1'b0;
      alloc_next   = 1;
      list_ok      = 1'b1;
   endfunction

   // walk the shadow trie for one transaction, update it, and return the result
   function automatic dtpc_pkg::result_type trie_step(dtpc_pkg::kind_type kind,
                                                      logic [DIGITS_W-1:0] digits,
                                                      logic [LEN_W-1:0] len_in);
      dtpc_pkg::result_type r;
      int unsigned n_dig, i, node, d, fresh;
      bit          complete;
      r = '0;
      if (kind == dtpc_pkg::KIND_CLEAR) begin
         trie_empty();
         r.list_consistent = 1'b1;
         return r;
      end
      // once a conflict is seen, checks are ignored until the next clear
      if (!list_ok)
         return r;
      n_dig = (len_in > DEPTH) ? DEPTH : len_in;

      // look for a stored number that is a prefix of this one
      node = 0;
      for (i = 0; i < n_dig; i++) begin
         d = digits[4*i +: 4];
         if (d >= RADIX || !node_kids[node][d])
            break;
         node = node_child[node*RADIX + d];
         if (node_end[node]) begin
            r.prefix_found  = 1'b1;
            r.prefix_length = 4'(i + 1);
            break;
         end
      end

      if (r.prefix_found) begin
         list_ok = 1'b0;
      end else begin
         // insert; an invalid digit or an empty pool cuts the path without an end mark
         complete = 1'b1;
         node = 0;
         for (i = 0; i < n_dig; i++) begin
            d = digits[4*i +: 4];
            if (d >= RADIX) begin
               complete = 1'b0;
               break;
            end
            if (!node_kids[node][d]) begin
               if (alloc_next >= NODES) begin
                  r.pool_full = 1'b1;
                  complete = 1'b0;
                  break;
               end
               fresh = alloc_next;
               alloc_next++;
               node_kids[fresh] = '0;
               node_end[fresh]  = 1'b0;
               node_child[node*RADIX + d] = 12'(fresh);
               node_kids[node][d] = 1'b1;
            end
            node = node_child[node*RADIX + d];
         end
         if (complete && node != 0)
            node_end[node] = 1'b1;
      end
      r.list_consistent = list_ok;
      return r;
   endfunction

   task automatic push_item(dtpc_pkg::kind_type kind, logic [DIGITS_W-1:0] digits,
                            logic [LEN_W-1:0] len_in, bit drain);
      queued_item_type q;
      q.item.kind   = kind;
      q.item.digits = digits;
      q.item.len    = len_in;
      q.drain       = drain;
      pending_items.insert(pending_items.size(), q);
   endtask

   // ten nibbles drawn from 0..top, with bad_pct percent of them invalid (10..15)
   function automatic logic [DIGITS_W-1:0] random_number(int unsigned top, int unsigned bad_pct);
      logic [DIGITS_W-1:0] v;
      int k;
      for (k = 0; k < DEPTH; k++)
         v[4*k +: 4] = ($urandom_range(0, 99) < bad_pct) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, top));
      return v;
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // monitor: result checks and request prediction, both at the rising edge
   always @(posedge clock) begin : watch_channels
      dtpc_pkg::result_type seen, want, predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            results_seen++;
            seen = rsp_tdata[6:0];
            if (awaited_results.size() == 0) begin
               $display("%0t ns: result with none expected, expected none, got %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("prefix_found", want.prefix_found, seen.prefix_found);
               check_field("prefix_length", want.prefix_length, seen.prefix_length);
               check_field("list_consistent", want.list_consistent, seen.list_consistent);
               check_field("pool_full", want.pool_full, seen.pool_full);
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            predicted = trie_step(dtpc_pkg::kind_type'(req_tuser[0]),
                                  req_tdata[DIGITS_W-1:0],
                                  req_tdata[DIGITS_W +: LEN_W]);
            awaited_results.insert(awaited_results.size(), predicted);
         end
      end
   end

   // request driver: one transaction offered at a time, random gap before each
   always @(negedge clock) begin : drive_requests
      logic            offer;
      queued_item_type slot;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_taken) begin
            req_taken = 1'b0;
            offer = 1'b0;
            if ($urandom_range(0, 63) == 0)
               send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 17);
         end
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && awaited_results.size() != 0)) begin
               slot = pending_items.pop_front();
               req_tdata <= {{(REQ_DATA_W-DIGITS_W-LEN_W){1'b0}},
                             slot.item.len, slot.item.digits};
               req_tuser <= slot.item.kind;
               offer = 1'b1;
            end
         end
         // single update of valid per step, so back-to-back offers stay high
         req_tvalid <= offer;
      end
   end

   // result receiver: random stall per result, plus one long hold to back up the block
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if (results_seen == HOLD_AT_RESULT)
               hold_left = HOLD_CYCLES;
            if ($urandom_range(0, 63) == 0)
               take_burst = !take_burst;
            stall_left = take_burst ? 0 : $urandom_range(0, 17);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned j, cnt, cur_len, mixed_count, top;
      logic [63:0] noise;

      trie_empty();

      // directed: empty number, prefix hit, ignored check, invalid digits, saturated length
      push_item(dtpc_pkg::KIND_CLEAR, 40'hFF_FFFF_FFFF, 4'd15, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h0, 4'd0, 1'b0);                 // empty number
      push_item(dtpc_pkg::KIND_CHECK, 40'h21, 4'd2, 1'b0);                // 12
      push_item(dtpc_pkg::KIND_CHECK, 40'h31, 4'd2, 1'b0);                // 13
      push_item(dtpc_pkg::KIND_CHECK, 40'h5521, 4'd4, 1'b0);              // 1255 hits 12
      push_item(dtpc_pkg::KIND_CHECK, 40'h7, 4'd1, 1'b0);       // ignored while inconsistent
      push_item(dtpc_pkg::KIND_CLEAR, 40'h0, 4'd0, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h3A1, 4'd3, 1'b0);               // invalid middle digit
      push_item(dtpc_pkg::KIND_CHECK, 40'h041, 4'd3, 1'b0);               // reuses the cut path
      push_item(dtpc_pkg::KIND_CHECK, 40'h99_9999_9999, 4'd15, 1'b0);     // length saturates
      push_item(dtpc_pkg::KIND_CHECK, 40'h0, 4'd10, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'hFF_FFFF_FFFF, 4'd10, 1'b0);     // invalid first digit
      push_item(dtpc_pkg::KIND_CHECK, 40'h0, 4'd12, 1'b0);                // full-length prefix hit
      push_item(dtpc_pkg::KIND_CLEAR, 40'h12_3456_789A, 4'd10, 1'b1);     // sender waits for drain
      push_item(dtpc_pkg::KIND_CHECK, 40'h0, 4'd1, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h98_7654_3210, 4'd10, 1'b0);     // hit at length 1
      push_item(dtpc_pkg::KIND_CLEAR, 40'h0, 4'd0, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'hF5, 4'd2, 1'b0);                // node made, no end mark
      push_item(dtpc_pkg::KIND_CHECK, 40'h5, 4'd1, 1'b0);                 // marks the existing node
      push_item(dtpc_pkg::KIND_CHECK, 40'h555, 4'd3, 1'b0);
      push_item(dtpc_pkg::KIND_CLEAR, 40'h0, 4'd0, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h8, 4'd1, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h8, 4'd1, 1'b0);                 // same number twice

      // random runs: mostly clear + nondecreasing lengths over a small alphabet,
      // some noise, and some runs that carry over without a clear
      mixed_count = 0;
      while (mixed_count < 50) begin
         if ($urandom_range(0, 5) != 0)
            push_item(dtpc_pkg::KIND_CLEAR, random_number(15, 0),
                      4'($urandom_range(0, 15)), 1'b0);
         case ($urandom_range(0, 2))
            0: top = 1;
            1: top = 2;
            default: top = 9;
         endcase
         cnt = $urandom_range(1, 14);
         cur_len = $urandom_range(0, 3);
         for (j = 0; j < cnt; j++) begin
            if ($urandom_range(0, 9) == 0) begin
               noise = {$urandom, $urandom};
               push_item(dtpc_pkg::kind_type'($urandom_range(0, 1)), noise[DIGITS_W-1:0],
                         4'($urandom_range(0, 15)), 1'b0);
            end else begin
               push_item(dtpc_pkg::KIND_CHECK, random_number(top, 4),
                         (cur_len == DEPTH && $urandom_range(0, 2) == 0) ?
                            4'($urandom_range(11, 15)) : 4'(cur_len), 1'b0);
               cur_len += $urandom_range(0, 2);
               if (cur_len > DEPTH)
                  cur_len = DEPTH;
            end
            mixed_count++;
         end
      end

      // pool exhaustion: enough distinct ten-digit numbers to use up every node
      push_item(dtpc_pkg::KIND_CLEAR, 40'h0, 4'd0, 1'b1);
      for (j = 0; j < 540; j++)
         push_item(dtpc_pkg::KIND_CHECK, random_number(9, 0), 4'd10, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h1, 4'd1, 1'b0);       // existing node, no allocation
      push_item(dtpc_pkg::KIND_CHECK, 40'h21, 4'd2, 1'b0);
      push_item(dtpc_pkg::KIND_CLEAR, 40'h0, 4'd0, 1'b0);
      push_item(dtpc_pkg::KIND_CHECK, 40'h321, 4'd3, 1'b0);     // pool usable again

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(negedge clock);
      // room for any stray result after the last one
      repeat (40) @(posedge clock);

      if (mismatches == 0 && awaited_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
